// File: src/sha224_hash_engine_core_defines.svh
// Assertion macros shared by the SHA-224 engine RTL.
// Depends on nothing; files that assert include it and provide clk and arst_n.
`ifndef SHA224_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA224_HASH_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sha224he_pkg.sv
// Types, constants and round functions of the SHA-224 engine.
// No dependencies; used by the round unit, the message schedule and the top level.
package sha224he_pkg;

	typedef logic [31:0] word_t;

	localparam logic [7:0]  PAD_BYTE      = 8'h80;
	localparam logic [5:0]  LEN_POS_LIMIT = 6'd56;
	localparam logic [5:0]  LAST_POS      = 6'd63;
	localparam logic [5:0]  LAST_ROUND    = 6'd63;
	localparam logic [2:0]  LAST_WORD_IDX = 3'd6;
	localparam logic [63:0] BYTE_BITS     = 64'd8;

	// control from the sequencer to the round unit
	typedef struct packed {
		logic load;    // working vars <= hash
		logic step;    // one compression round
		logic accum;   // hash += working vars
		logic reinit;  // hash <= initial value
	} rnd_ctl_t;

	// control from the sequencer to the block buffer / schedule
	typedef struct packed {
		logic        wr_byte;
		logic [5:0]  pos;
		logic [7:0]  byte_val;
		logic        wr_len;
		logic [63:0] len;
		logic        shift;
		logic        clear;
	} msg_ctl_t;

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'hc1059ed8;
			3'd1: r = 32'h367cd507;
			3'd2: r = 32'h3070dd17;
			3'd3: r = 32'hf70e5939;
			3'd4: r = 32'hffc00b31;
			3'd5: r = 32'h68581511;
			3'd6: r = 32'h64f98fa7;
			3'd7: r = 32'hbefa4fa4;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: src/sha224he_msg_sched.sv
// Block buffer of the SHA-224 engine: byte packing, length insertion and
// the rolling 16-word message schedule. Depends on sha224he_pkg.
module sha224he_msg_sched import sha224he_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  msg_ctl_t ctl,
	output word_t    w_cur
);

	word_t buf_q [16];
	word_t w_next;

	// W[t] = ssig1(W[t-2]) + W[t-7] + ssig0(W[t-15]) + W[t-16]
	assign w_next = buf_q[0] + ssig0(buf_q[1]) + buf_q[9] + ssig1(buf_q[14]);
	assign w_cur  = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
		end else if (ctl.shift) begin
			for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
			buf_q[15] <= w_next;
		end else begin
			if (ctl.wr_byte) begin
				// big-endian lanes: byte 0 of a word lands in bits 31:24
				case (ctl.pos[1:0])
					2'd0: buf_q[ctl.pos[5:2]][31:24] <= ctl.byte_val;
					2'd1: buf_q[ctl.pos[5:2]][23:16] <= ctl.byte_val;
					2'd2: buf_q[ctl.pos[5:2]][15:8]  <= ctl.byte_val;
					2'd3: buf_q[ctl.pos[5:2]][7:0]   <= ctl.byte_val;
					default: buf_q[ctl.pos[5:2]][7:0] <= ctl.byte_val;
				endcase
			end
			if (ctl.wr_len) begin
				buf_q[14] <= ctl.len[63:32];
				buf_q[15] <= ctl.len[31:0];
			end
		end
	end

endmodule

// File: src/sha224he_round.sv
// SHA-224 round unit: hash state, working variables and the shared round datapath.
// Depends on sha224he_pkg.
module sha224he_round import sha224he_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rnd_ctl_t   ctl,
	input  logic [5:0] rnd,
	input  word_t      w_cur,
	input  logic [2:0] out_idx,
	output word_t      out_word
);

	word_t hash_q [8];
	word_t wv_q   [8];
	word_t ch, maj, t1, t2;

	always_comb begin
		ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1  = wv_q[7] + bsig1(wv_q[4]) + ch + round_k(rnd) + w_cur;
		t2  = bsig0(wv_q[0]) + maj;
	end

	assign out_word = hash_q[out_idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
		end else if (ctl.step) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else if (ctl.reinit) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else if (ctl.accum) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
		end
	end

endmodule

// File: src/sha224_hash_engine_core.sv
// SHA-224 engine top level: transaction sequencer, bit counter and stream ports.
// Depends on sha224he_pkg, sha224he_msg_sched, sha224he_round and the defines header.
//
// Usage:
//  Input stream s_axis_*: one message byte per transaction in tdata[7:0];
//  tuser marks that the byte is valid (tuser = 0 with tlast = 1 ends the
//  message without a byte), tlast ends the message. tuser = 0, tlast = 0 is a no-op.
//  Output stream m_axis_*: seven digest words h0..h6, tuser = word position,
//  tlast on the seventh word.
//  Flow: a byte that does not complete a 64-byte block leaves the engine ready
//  for the next byte. A byte that completes a block is followed by the load,
//  64 rounds through the single round unit and the hash update. On tlast the
//  pad byte is written, then one extra block is compressed when the pad byte
//  lands at offset 56 or later, then the length words and the final block;
//  then the seven words are offered, one per cycle when m_axis_tready is high.
//  s_axis_tready is low from the cycle after a busy transaction until it ends.
//  A stalled receiver simply holds the current word; nothing is lost.
//  Reset: hash state to the SHA-224 initial value, buffer and counters to zero,
//  ready to accept in the first cycle after arst_n rises.
`include "sha224_hash_engine_core_defines.svh"
module sha224_hash_engine_core import sha224he_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_pos
	output logic        m_axis_tlast    // last_word
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_COMP = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]  state_q, after_q;
	logic [5:0]  round_q, pos_q;
	logic [63:0] bit_cnt_q;
	logic [2:0]  out_idx_q;
	logic        in_acc, out_acc;
	msg_ctl_t    mctl;
	rnd_ctl_t    rctl;
	word_t       w_cur, out_word;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = out_word;
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = (out_idx_q == LAST_WORD_IDX);

	always_comb begin
		mctl          = '0;
		mctl.pos      = pos_q;
		mctl.byte_val = (state_q == ST_PAD) ? PAD_BYTE : s_axis_tdata;
		mctl.wr_byte  = (in_acc && s_axis_tuser) || (state_q == ST_PAD);
		mctl.wr_len   = (state_q == ST_LEN);
		mctl.len      = bit_cnt_q;
		mctl.shift    = (state_q == ST_COMP);
		mctl.clear    = (state_q == ST_FIN);

		rctl          = '0;
		rctl.load     = (state_q == ST_LOAD);
		rctl.step     = (state_q == ST_COMP);
		rctl.accum    = (state_q == ST_FIN);
		rctl.reinit   = out_acc && m_axis_tlast;
	end

	sha224he_msg_sched u_msg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.w_cur  (w_cur)
	);

	sha224he_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rctl),
		.rnd      (round_q),
		.w_cur    (w_cur),
		.out_idx  (out_idx_q),
		.out_word (out_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			after_q   <= ST_IDLE;
			round_q   <= '0;
			pos_q     <= '0;
			bit_cnt_q <= '0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser) begin
							pos_q     <= pos_q + 6'd1;
							bit_cnt_q <= bit_cnt_q + BYTE_BITS;
						end
						if (s_axis_tuser && pos_q == LAST_POS) begin
							// block full: compress, then pad if this ended the message
							state_q <= ST_LOAD;
							after_q <= s_axis_tlast ? ST_PAD : ST_IDLE;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (pos_q >= LEN_POS_LIMIT) begin
						// no room for the length: flush this block first
						state_q <= ST_LOAD;
						after_q <= ST_LEN;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					state_q <= ST_LOAD;
					after_q <= ST_OUT;
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) state_q <= ST_FIN;
				end
				ST_FIN: begin
					pos_q     <= '0;
					out_idx_q <= '0;
					state_q   <= after_q;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == LAST_WORD_IDX) begin
							state_q   <= ST_IDLE;
							bit_cnt_q <= '0;
							pos_q     <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_NOW(a_out_blocks_in, m_axis_tvalid, !s_axis_tready,
		"input accepted while digest words are pending")
	`SHA_ASSERT_NOW(a_out_idx_range, m_axis_tvalid, out_idx_q <= LAST_WORD_IDX,
		"digest word position out of range")
	`SHA_ASSERT_NOW(a_out_pos_zero, state_q == ST_OUT, pos_q == '0,
		"byte position not cleared after final block")
	`SHA_ASSERT_NEXT(a_load_starts_rounds, state_q == ST_LOAD,
		state_q == ST_COMP && round_q == '0, "compression did not start at round zero")
	`SHA_ASSERT_NEXT(a_digest_done_clears, out_acc && m_axis_tlast,
		state_q == ST_IDLE && bit_cnt_q == '0, "engine not restored after digest")

endmodule

// File: tb/sha224_tb_pkg.sv
`timescale 1ns / 100ps
// SHA-224 digest predictor and result checker for the hash engine testbench.
// Self-contained; tb_top feeds it accepted input transactions and output words.
package sha224_tb_pkg;

	localparam logic [31:0] IV224 [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_ROOM   = 6'd56;
	localparam int         DIGEST_LEN = 7;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        lst;
	} digest_beat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	class digest_tracker;
		logic [31:0]  chain [8];
		logic [31:0]  blk [16];
		logic [5:0]   fill;
		logic [63:0]  msg_bits;
		digest_beat_t words_due [$];
		int unsigned  mismatches;
		int unsigned  words_seen;
		int unsigned  digests_due;

		function new();
			mismatches = 0;
			words_seen = 0;
			digests_due = 0;
			restart();
		endfunction

		function void restart();
			chain = IV224;
			foreach (blk[i]) blk[i] = '0;
			fill = '0;
			msg_bits = '0;
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1;
			logic [31:0] t2;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int i = 16; i < 64; i++) begin
				w[i] = w[i-16] + w[i-7]
					+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
			end
			v = chain;
			for (int r = 0; r < 64; r++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] += v[i];
			foreach (blk[i]) blk[i] = '0;
		endfunction

		// big-endian packing; a full block is compressed at once
		function void push_byte(logic [7:0] b);
			blk[fill[5:2]] |= {24'd0, b} << (8 * (3 - fill[1:0]));
			fill = fill + 6'd1;
			if (fill == '0)
				compress();
		endfunction

		// note one accepted input transaction
		function void take_item(logic [7:0] b, logic has_b, logic ends);
			digest_beat_t beat;
			if (has_b) begin
				push_byte(b);
				msg_bits += 64'd8;
			end
			if (!ends)
				return;
			push_byte(PAD_MARK);
			// no room left for the length words: flush an extra block
			if (fill > LEN_ROOM) begin
				compress();
				fill = '0;
			end
			blk[14] = msg_bits[63:32];
			blk[15] = msg_bits[31:0];
			compress();
			for (int i = 0; i < DIGEST_LEN; i++) begin
				beat.word = chain[i];
				beat.idx  = 3'(i);
				beat.lst  = (i == DIGEST_LEN - 1);
				words_due.push_back(beat);
			end
			digests_due++;
			restart();
		endfunction

		// check one accepted output transaction against the oldest pending word
		function void check_word(logic [31:0] word, logic [2:0] idx, logic lst);
			digest_beat_t exp_b;
			words_seen++;
			if (words_due.size() == 0) begin
				$error("digest_word %08h arrived with no digest pending", word);
				mismatches++;
				return;
			end
			exp_b = words_due.pop_front();
			if (word !== exp_b.word) begin
				$error("digest_word: expected %08h, got %08h", exp_b.word, word);
				mismatches++;
			end
			if (idx !== exp_b.idx) begin
				$error("word_pos: expected %0d, got %0d", exp_b.idx, idx);
				mismatches++;
			end
			if (lst !== exp_b.lst) begin
				$error("last_word: expected %0b, got %0b", exp_b.lst, lst);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for sha224_hash_engine_core: byte stream in, digest words out.
// Depends on sha224_tb_pkg for the digest predictor and on the engine RTL.
module tb_top;
	import sha224_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned RAND_ITEMS   = 130;
	localparam int unsigned MIN_PHASES   = 4;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned SETTLE_WAIT  = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	digest_tracker sha_ref = new();

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_cnt = 0;
	int unsigned items_sent = 0;
	int unsigned bytes_sent = 0;
	int unsigned hold_left = 0;
	bit          hold_req = 1'b0;

	sha224_hash_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sha_ref.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic has_b, input logic ends);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= has_b;
		s_axis_tlast <= ends;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sha_ref.take_item(b, has_b, ends);
		if (has_b || ends)
			items_sent++;
		if (has_b)
			bytes_sent++;
	endtask

	// random bytes with a sprinkling of no-op transactions; ends with the byte
	// itself or with an empty final transaction
	task automatic send_message(input int unsigned len, input bit empty_tail);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, !empty_tail && (i == len - 1));
		end
		if (empty_tail || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic pause_and_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sha_ref.words_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned phase;
		int unsigned len;
		int unsigned sel;
		int unsigned base_items;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: no-ops, empty message, byte extremes, "abc", empty tail
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h01, 1'b1, 1'b1);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		pause_and_drain();

		// output held off while the sender keeps pushing; the input must back up
		hold_req = 1'b1;
		send_message(5, 1'b0);
		send_message(3, 1'b1);
		send_message(2, 1'b0);
		pause_and_drain();

		base_items = items_sent;
		phase = 0;
		while (items_sent - base_items < RAND_ITEMS || phase < MIN_PHASES) begin
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_gap_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			sel = $urandom_range(99);
			// bias toward lengths around the padding boundaries
			if (sel < 45)
				len = $urandom_range(12);
			else if (sel < 85)
				len = $urandom_range(70, 52);
			else
				len = $urandom_range(140);
			send_message(len, $urandom_range(3) == 0);
			pause_and_drain();
			phase++;
		end

		send_gap_pct = 0;
		recv_stall_pct = 0;
		repeat (SETTLE_WAIT) @(posedge clk);
		if (sha_ref.words_due.size() != 0) begin
			$error("%0d digest words never arrived", sha_ref.words_due.size());
			sha_ref.mismatches++;
		end

		$display("Run: %0d messages, %0d bytes, %0d digest words checked, %0d mismatches",
			sha_ref.digests_due, bytes_sent, sha_ref.words_seen, sha_ref.mismatches);
		$display("Flow: %0d stall mixes, a %0d-cycle output hold, drained pauses",
			phase, HOLD_CYCLES);
		if (sha_ref.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
